@@ hdl/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ENT          = 9;
    localparam int BAND_W         = 16;

    // transposed cofactor k = m[a]*m[b] - m[c]*m[d], entries row-major
    localparam int COF_TERMS [N_ENT][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // cofactors that pair with the top row in the determinant
    localparam int DET_COF [3] = '{0, 3, 6};

endpackage
`default_nettype wire

@@ hdl/mi3_in_if.sv @@
`default_nettype none
interface mi3_in_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic signed [W-1:0] m_r0c0;
    logic signed [W-1:0] m_r0c1;
    logic signed [W-1:0] m_r0c2;
    logic signed [W-1:0] m_r1c0;
    logic signed [W-1:0] m_r1c1;
    logic signed [W-1:0] m_r1c2;
    logic signed [W-1:0] m_r2c0;
    logic signed [W-1:0] m_r2c1;
    logic signed [W-1:0] m_r2c2;

    modport source (
        output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
               m_r2c0, m_r2c1, m_r2c2,
        input  ready
    );
    modport sink (
        input  valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
               m_r2c0, m_r2c1, m_r2c2,
        output ready
    );
endinterface
`default_nettype wire

@@ hdl/mi3_out_if.sv @@
`default_nettype none
interface mi3_out_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic signed [W-1:0] inv_r0c0;
    logic signed [W-1:0] inv_r0c1;
    logic signed [W-1:0] inv_r0c2;
    logic signed [W-1:0] inv_r1c0;
    logic signed [W-1:0] inv_r1c1;
    logic signed [W-1:0] inv_r1c2;
    logic signed [W-1:0] inv_r2c0;
    logic signed [W-1:0] inv_r2c1;
    logic signed [W-1:0] inv_r2c2;
    logic                singular;
    logic                overflow;

    modport source (
        output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular, overflow,
        input  ready
    );
    modport sink (
        input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular, overflow,
        output ready
    );
endinterface
`default_nettype wire

@@ hdl/matrix_inverse_3x3.sv @@
// Channel   Dir  Handshake        Payload
// i_in      in   valid/ready      m_r0c0 .. m_r2c2, signed Q(W-F).F
// o_out     out  valid/ready      inv_r0c0 .. inv_r2c2, singular, overflow
// i_cfg     in   write enable     zero_band, 16 bits
//
// One matrix per cycle while o_out is not stalled. The pipeline has six
// stages of products and sums, a setup stage, one range check plus one
// quotient bit per stage in the nine parallel dividers (DATA_WIDTH + 2),
// and the output register. Reset clears all valid bits and zero_band. A stall
// at o_out freezes every stage at once; i_in.ready follows the output register.
`default_nettype none
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [BAND_W-1:0]  i_cfg_data,
    mi3_in_if.sink             i_in,
    mi3_out_if.source          o_out
);

    localparam int W   = DATA_WIDTH;
    localparam int CW  = 2 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NR  = CW + 2 * FRAC_BITS + 1;
    localparam int NW  = ((NR > DW) ? NR : DW) + 1;
    localparam int XW  = NW + W + 2;
    localparam int QW  = W + 1;
    localparam int DS  = W + 2;
    localparam int PW  = 2 * W + 1;

    logic ce;

    logic [BAND_W-1:0] r_band;

    logic r_av, r_bv, r_cv, r_dv, r_ev, r_fv, r_ov;
    logic r_qv [0:DS];

    logic signed [W-1:0]    n_m  [N_ENT];
    logic signed [W-1:0]    r_m  [N_ENT];
    logic signed [2*W-1:0]  r_p  [2*N_ENT];
    logic signed [W-1:0]    r_bm [3];
    logic signed [CW-1:0]   r_cc [N_ENT];
    logic signed [W-1:0]    r_cm [3];
    logic signed [PW-1:0]   r_dl [3];
    logic signed [PW-1:0]   r_dh [3];
    logic signed [CW-1:0]   r_dc [N_ENT];
    logic signed [DW-1:0]   r_et [3];
    logic signed [CW-1:0]   r_ec [N_ENT];
    logic signed [DW-1:0]   r_det;
    logic signed [CW-1:0]   r_fc [N_ENT];

    logic [NW-1:0] r_rm [0:DS][N_ENT];
    logic [NW-1:0] n_rm [0:DS][N_ENT];
    logic [QW-1:0] r_qt [0:DS][N_ENT];
    logic [QW-1:0] n_qt [0:DS][N_ENT];
    logic          r_bg [0:DS][N_ENT];
    logic          n_bg [0:DS][N_ENT];
    logic          r_ng [0:DS][N_ENT];
    logic          n_ng [0:DS][N_ENT];
    logic [DW-1:0] r_dn [0:DS];
    logic [DW-1:0] n_dn [0:DS];
    logic          r_sg [0:DS];
    logic          n_sg [0:DS];

    logic signed [W-1:0] r_inv [N_ENT];
    logic signed [W-1:0] n_inv [N_ENT];
    logic                r_sing, n_sing;
    logic                r_ovf, n_ovf;

    assign ce         = !r_ov || o_out.ready;
    assign i_in.ready = ce;

    assign n_m[0] = i_in.m_r0c0;
    assign n_m[1] = i_in.m_r0c1;
    assign n_m[2] = i_in.m_r0c2;
    assign n_m[3] = i_in.m_r1c0;
    assign n_m[4] = i_in.m_r1c1;
    assign n_m[5] = i_in.m_r1c2;
    assign n_m[6] = i_in.m_r2c0;
    assign n_m[7] = i_in.m_r2c1;
    assign n_m[8] = i_in.m_r2c2;

    // setup stage and divider stages
    always_comb begin
        logic [CW-1:0] acof;
        logic [DW-1:0] aden;
        logic [XW-1:0] sh;
        int            k;
        aden = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        n_dn[0] = DW'(aden << 1);
        n_sg[0] = (r_det == '0);
        for (int l = 0; l < N_ENT; l++) begin
            acof = r_fc[l][CW-1] ? CW'(-r_fc[l]) : CW'(r_fc[l]);
            n_ng[0][l] = r_fc[l][CW-1] ^ r_det[DW-1];
            n_rm[0][l] = (NW'(acof) << (2 * FRAC_BITS + 1)) + NW'(aden);
            n_qt[0][l] = '0;
            n_bg[0][l] = 1'b0;
        end
        for (int s = 1; s <= DS; s++) begin
            n_dn[s] = r_dn[s-1];
            n_sg[s] = r_sg[s-1];
            k = DS - s;
            for (int l = 0; l < N_ENT; l++) begin
                n_ng[s][l] = r_ng[s-1][l];
                n_rm[s][l] = r_rm[s-1][l];
                n_qt[s][l] = r_qt[s-1][l];
                n_bg[s][l] = r_bg[s-1][l];
                if (s == 1) begin
                    // quotient too large for the kept bits
                    sh = XW'(r_dn[s-1]) << QW;
                    n_bg[s][l] = (XW'(r_rm[s-1][l]) >= sh);
                end else begin
                    sh = XW'(r_dn[s-1]) << k;
                    if (XW'(r_rm[s-1][l]) >= sh) begin
                        n_rm[s][l] = r_rm[s-1][l] - NW'(sh);
                        n_qt[s][l] = r_qt[s-1][l] | (QW'(1) << k);
                    end
                end
            end
        end
    end

    // band, saturation, singular
    always_comb begin
        logic [QW-1:0] mag;
        logic [QW-1:0] half;
        half  = QW'(1) << (W - 1);
        n_ovf = 1'b0;
        n_sing = r_sg[DS];
        for (int l = 0; l < N_ENT; l++) begin
            mag = r_qt[DS][l];
            n_inv[l] = '0;
            if (r_sg[DS]) begin
                n_inv[l] = '0;
            end else if (!r_bg[DS][l] && (mag < QW'(r_band))) begin
                n_inv[l] = '0;
            end else if (r_ng[DS][l]) begin
                if (r_bg[DS][l] || (mag > half)) begin
                    n_inv[l] = W'(~half + QW'(1));
                    n_ovf    = 1'b1;
                end else begin
                    n_inv[l] = W'(~mag + QW'(1));
                end
            end else begin
                if (r_bg[DS][l] || (mag > half - QW'(1))) begin
                    n_inv[l] = W'(half - QW'(1));
                    n_ovf    = 1'b1;
                end else begin
                    n_inv[l] = W'(mag);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= '0;
            r_av   <= 1'b0;
            r_bv   <= 1'b0;
            r_cv   <= 1'b0;
            r_dv   <= 1'b0;
            r_ev   <= 1'b0;
            r_fv   <= 1'b0;
            r_ov   <= 1'b0;
            for (int s = 0; s <= DS; s++) r_qv[s] <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_band <= i_cfg_data;
            end
            if (ce) begin
                r_av    <= i_in.valid;
                r_bv    <= r_av;
                r_cv    <= r_bv;
                r_dv    <= r_cv;
                r_ev    <= r_dv;
                r_fv    <= r_ev;
                r_qv[0] <= r_fv;
                for (int s = 1; s <= DS; s++) r_qv[s] <= r_qv[s-1];
                r_ov    <= r_qv[DS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_m <= n_m;
            // cofactor products
            for (int k = 0; k < N_ENT; k++) begin
                r_p[2*k]   <= (2*W)'(r_m[COF_TERMS[k][0]]) * (2*W)'(r_m[COF_TERMS[k][1]]);
                r_p[2*k+1] <= (2*W)'(r_m[COF_TERMS[k][2]]) * (2*W)'(r_m[COF_TERMS[k][3]]);
            end
            for (int j = 0; j < 3; j++) r_bm[j] <= r_m[j];
            for (int k = 0; k < N_ENT; k++) begin
                r_cc[k] <= CW'(r_p[2*k]) - CW'(r_p[2*k+1]);
            end
            r_cm <= r_bm;
            // determinant terms, cofactor split into low and high halves
            for (int j = 0; j < 3; j++) begin
                r_dl[j] <= PW'(r_cm[j]) * PW'($signed({1'b0, r_cc[DET_COF[j]][W-1:0]}));
                r_dh[j] <= PW'(r_cm[j]) * PW'($signed(r_cc[DET_COF[j]][CW-1:W]));
            end
            r_dc <= r_cc;
            for (int j = 0; j < 3; j++) begin
                r_et[j] <= (DW'(r_dh[j]) <<< W) + DW'(r_dl[j]);
            end
            r_ec  <= r_dc;
            r_det <= r_et[0] + r_et[1] + r_et[2];
            r_fc  <= r_ec;
            r_rm  <= n_rm;
            r_qt  <= n_qt;
            r_bg  <= n_bg;
            r_ng  <= n_ng;
            r_dn  <= n_dn;
            r_sg  <= n_sg;
            r_inv  <= n_inv;
            r_sing <= n_sing;
            r_ovf  <= n_ovf;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.inv_r0c0 = r_inv[0];
    assign o_out.inv_r0c1 = r_inv[1];
    assign o_out.inv_r0c2 = r_inv[2];
    assign o_out.inv_r1c0 = r_inv[3];
    assign o_out.inv_r1c1 = r_inv[4];
    assign o_out.inv_r1c2 = r_inv[5];
    assign o_out.inv_r2c0 = r_inv[6];
    assign o_out.inv_r2c1 = r_inv[7];
    assign o_out.inv_r2c2 = r_inv[8];
    assign o_out.singular = r_sing;
    assign o_out.overflow = r_ovf;

endmodule
`default_nettype wire

@@ sim/matrix_inverse_3x3_test.sv @@
`default_nettype none
module matrix_inverse_3x3_test;
    import mi3_pkg::*;

    localparam int W = DATA_WIDTH_DEF;

    typedef logic signed [W-1:0] entry_t;
    typedef entry_t mat_t [N_ENT];

    typedef struct {
        mat_t inv;
        logic singular;
        logic overflow;
    } inverse_t;

    // predicts each inverse exactly and keeps the ones still in flight
    class inverse_scoreboard;
        inverse_t pending [$];
        logic [BAND_W-1:0] band;
        int errors;
        int n_checked;
        int n_singular;
        int n_overflow;

        function new();
            band = '0;
            errors = 0;
            n_checked = 0;
            n_singular = 0;
            n_overflow = 0;
        endfunction

        function automatic logic [W-1:0] scale(logic signed [127:0] cof,
                                               logic signed [127:0] det,
                                               inout logic ovf);
            logic [255:0] n, d, q;
            logic [63:0] mag;
            logic neg, huge;
            neg = cof[127] ^ det[127];
            n = 256'(cof[127] ? -cof : cof) << (2 * FRAC_BITS_DEF);
            d = 256'(det[127] ? -det : det);
            // round half away from zero: (2n + d) / 2d
            q = ((n << 1) + d) / (d << 1);
            huge = |q[255:64];
            mag = q[63:0];
            if (!huge && mag < 64'(band))
                return '0;
            if (neg) begin
                if (huge || mag > (64'd1 << (W - 1))) begin
                    mag = 64'd1 << (W - 1);
                    ovf = 1'b1;
                end
                return W'(-mag);
            end
            if (huge || mag > (64'd1 << (W - 1)) - 1) begin
                mag = (64'd1 << (W - 1)) - 1;
                ovf = 1'b1;
            end
            return W'(mag);
        endfunction

        function automatic void note_input(mat_t m);
            logic signed [127:0] x [N_ENT];
            logic signed [127:0] c [N_ENT];
            logic signed [127:0] det;
            inverse_t r;
            logic ovf;
            for (int k = 0; k < N_ENT; k++) x[k] = m[k];
            // transposed cofactors, row-major entries 0..8
            c[0] = x[4] * x[8] - x[5] * x[7];
            c[1] = x[2] * x[7] - x[1] * x[8];
            c[2] = x[1] * x[5] - x[2] * x[4];
            c[3] = x[5] * x[6] - x[3] * x[8];
            c[4] = x[0] * x[8] - x[2] * x[6];
            c[5] = x[2] * x[3] - x[0] * x[5];
            c[6] = x[3] * x[7] - x[4] * x[6];
            c[7] = x[1] * x[6] - x[0] * x[7];
            c[8] = x[0] * x[4] - x[1] * x[3];
            det = x[0] * c[0] + x[1] * c[3] + x[2] * c[6];
            ovf = 1'b0;
            if (det == 0) begin
                for (int k = 0; k < N_ENT; k++) r.inv[k] = '0;
                r.singular = 1'b1;
            end else begin
                for (int k = 0; k < N_ENT; k++) r.inv[k] = scale(c[k], det, ovf);
                r.singular = 1'b0;
            end
            r.overflow = ovf;
            pending.push_back(r);
        endfunction

        function automatic void check_result(inverse_t got);
            inverse_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (e.singular) n_singular++;
            if (e.overflow) n_overflow++;
            for (int k = 0; k < N_ENT; k++)
                if (got.inv[k] !== e.inv[k]) begin
                    $display("%0t: entry %0d expected %h actual %h",
                             $time, k, e.inv[k], got.inv[k]);
                    errors++;
                end
            if (got.singular !== e.singular) begin
                $display("%0t: singular expected %b actual %b",
                         $time, e.singular, got.singular);
                errors++;
            end
            if (got.overflow !== e.overflow) begin
                $display("%0t: overflow expected %b actual %b",
                         $time, e.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [BAND_W-1:0] i_cfg_data;

    mi3_in_if  #(.W(W)) in_ch ();
    mi3_out_if #(.W(W)) out_ch ();

    matrix_inverse_3x3 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    inverse_scoreboard sb = new();
    int n_sent = 0;
    int n_received = 0;
    logic long_hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("*** FAILED ***");
        $finish;
    end

    // transfer monitor
    always @(posedge i_clk) begin
        mat_t m;
        inverse_t r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            m = '{in_ch.m_r0c0, in_ch.m_r0c1, in_ch.m_r0c2,
                  in_ch.m_r1c0, in_ch.m_r1c1, in_ch.m_r1c2,
                  in_ch.m_r2c0, in_ch.m_r2c1, in_ch.m_r2c2};
            sb.note_input(m);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.inv = '{out_ch.inv_r0c0, out_ch.inv_r0c1, out_ch.inv_r0c2,
                      out_ch.inv_r1c0, out_ch.inv_r1c1, out_ch.inv_r1c2,
                      out_ch.inv_r2c0, out_ch.inv_r2c1, out_ch.inv_r2c2};
            r.singular = out_ch.singular;
            r.overflow = out_ch.overflow;
            sb.check_result(r);
            n_received++;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // receiver: random stalls, one long hold so the pipeline backs up
    initial begin
        int burst;
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && n_received >= 400) begin
                long_hold_done = 1'b1;
                out_ch.ready = 1'b0;
                repeat (300) @(negedge i_clk);
            end
            burst = ($urandom_range(9) == 0) ? 200 : $urandom_range(20, 1);
            out_ch.ready = 1'b1;
            repeat (burst) @(negedge i_clk);
            gap = gap_len();
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_matrix(mat_t m, bit allow_gap);
        int gap;
        gap = allow_gap ? gap_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        {in_ch.m_r0c0, in_ch.m_r0c1, in_ch.m_r0c2} = {m[0], m[1], m[2]};
        {in_ch.m_r1c0, in_ch.m_r1c1, in_ch.m_r1c2} = {m[3], m[4], m[5]};
        {in_ch.m_r2c0, in_ch.m_r2c1, in_ch.m_r2c2} = {m[6], m[7], m[8]};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic finish_sending();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_band(logic [BAND_W-1:0] v);
        finish_sending();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        sb.band = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic entry_t fix(int v);
        return entry_t'(v) <<< FRAC_BITS_DEF;
    endfunction

    function automatic mat_t diag(entry_t a, entry_t b, entry_t c);
        return '{a, 0, 0, 0, b, 0, 0, 0, c};
    endfunction

    function automatic mat_t random_matrix();
        mat_t m;
        int kind;
        kind = $urandom_range(99);
        for (int k = 0; k < N_ENT; k++) begin
            if (kind < 15)
                m[k] = $urandom;
            else if (kind < 25)
                m[k] = fix($urandom_range(6)) - fix(3);
            else if (kind < 35)
                m[k] = entry_t'($urandom_range(4000)) - 2000;
            else if (kind < 45)
                m[k] = entry_t'($urandom_range(2047)) - 1024;
            else if ((k % 4) == 0)
                // well-conditioned: heavy diagonal with random sign
                m[k] = ($urandom_range(1) ? 1 : -1) *
                       (fix($urandom_range(64, 3)) + entry_t'($urandom_range(65535)));
            else
                m[k] = entry_t'($urandom_range(131071)) - 65536;
        end
        if (kind >= 35 && kind < 45) begin
            // bottom row is the sum of the others: exactly singular
            for (int j = 0; j < 3; j++) m[6 + j] = m[j] + m[3 + j];
        end
        return m;
    endfunction

    initial begin
        mat_t d [$];
        logic [BAND_W-1:0] bands [5];
        in_ch.valid = 1'b0;
        {in_ch.m_r0c0, in_ch.m_r0c1, in_ch.m_r0c2} = '0;
        {in_ch.m_r1c0, in_ch.m_r1c1, in_ch.m_r1c2} = '0;
        {in_ch.m_r2c0, in_ch.m_r2c1, in_ch.m_r2c2} = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity, singular, extremes, band and saturation edges
        d.push_back(diag(fix(1), fix(1), fix(1)));
        d.push_back('{default: 0});
        d.push_back('{default: entry_t'(32'h7FFF_FFFF)});
        d.push_back('{default: entry_t'(32'h8000_0000)});
        d.push_back(diag(entry_t'(32'h7FFF_FFFF), entry_t'(32'h8000_0000), fix(-1)));
        d.push_back(diag(1, 1, 1));
        d.push_back(diag(-1, 2, fix(1)));
        d.push_back(diag(fix(2), fix(-4), fix(16384)));
        d.push_back(diag(entry_t'(32'h8000_0000), fix(1), fix(1)));
        d.push_back(diag(fix(1), 65537, fix(3)));
        d.push_back('{fix(1), fix(2), fix(3), fix(4), fix(5), fix(6), fix(7), fix(8), fix(10)});
        d.push_back('{fix(1), fix(2), fix(3), fix(2), fix(4), fix(6), fix(7), fix(8), fix(9)});
        d.push_back('{0, fix(1), 0, 0, 0, fix(1), fix(1), 0, 0});
        d.push_back('{fix(3), 0, fix(2), fix(2), 0, -fix(2), 0, fix(1), fix(1)});
        d.push_back('{entry_t'(32'h5555_5555), entry_t'(32'hAAAA_AAAA), 1, 2,
                      entry_t'(32'h7FFF_FFFF), 3, entry_t'(32'h8000_0000), 4, 5});
        d.push_back(diag(fix(-3), fix(-3), fix(-3)));
        d.push_back(diag(2, 3, 4));

        bands = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(65535)), 16'($urandom_range(200))};
        for (int ph = 0; ph < 5; ph++) begin
            write_band(bands[ph]);
            foreach (d[i]) send_matrix(d[i], 1'b0);
            for (int i = 0; i < 380; i++) send_matrix(random_matrix(), ph != 2 || i > 100);
        end
        finish_sending();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (out_ch.valid === 1'b1) begin
            $display("%0t: result transfer offered with nothing expected", $time);
            sb.errors++;
        end
        $display("Sent %0d matrices over 5 zero-band settings; checked %0d inverses",
                 n_sent, sb.n_checked);
        $display("  of them %0d singular and %0d saturated", sb.n_singular, sb.n_overflow);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
hdl/mi3_pkg.sv
hdl/mi3_in_if.sv
hdl/mi3_out_if.sv
hdl/matrix_inverse_3x3.sv
sim/matrix_inverse_3x3_test.sv
